[rtl/bmp565_pkg.sv]
// Shared types and constants for the BMP 24-bit to RGB565 stream decoder.
`timescale 1ns / 1ps

package bmp565_pkg;

  // Frame size limits and field widths
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int FRAME_W    = 11;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = 20;
  localparam int RGB_W      = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // BMP header constants
  localparam logic [15:0] BMP_SIGNATURE  = 16'h4D42;
  localparam logic [15:0] BMP_DEPTH      = 16'd24;
  localparam logic [31:0] HEADER_BYTES   = 32'd54;
  localparam logic [31:0] LAST_HDR_POS   = 32'd53;

  // Register reset values and register indexes
  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 11'd320;
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 11'd240;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Result kinds
  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  // Depth of the queue between the parser and the output stage
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Parser phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_PAD,
    PH_DONE
  } phase_t;

  // One pending result, as handed from the parser to the output stage
  typedef struct packed {
    logic              kind;
    logic              last;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [ADDR_W-1:0] row_base;
    logic [COL_W-1:0]  col;
  } token_t;

endpackage

[rtl/bmp24_to_rgb565_stream_decoder.sv]
// Top level: configuration registers and the parser, queue and output stage.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid/in_stall) carries a BMP file one byte per
// transaction; in_file_start marks byte 0 and restarts parsing at any time.
// Bytes outside a file are dropped. The 54-byte header is checked against
// frame_width/frame_height (APB registers at 0x0 and 0x4, reset 320 x 240),
// a 'BM' signature and 24-bit depth. A failed check gives one reject
// transaction (out_result_kind = 1), then the file is ignored.
// Otherwise every B,G,R triple gives one pixel transaction with its RGB565
// value and top-down frame address; out_last_pixel flags the final one.
// Throughput is one byte per cycle while in_stall is low, set by the parser's
// single-step update. A result is written into the queue at the edge that accepts
// the byte which completes it, then moves into the output register, from which
// the receiver takes it.
// When the receiver stalls, the output register holds, the two-entry queue
// fills, and in_stall rises until space frees up.
// Reset returns the parser to waiting for a file start, empties the queue
// and output register, and restores the frame size registers.

module bmp24_to_rgb565_stream_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_data_byte,
  input  logic                              in_file_start,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_result_kind,
  output logic [bmp565_pkg::RGB_W-1:0]      out_pixel_rgb565,
  output logic [bmp565_pkg::ADDR_W-1:0]     out_pixel_address,
  output logic                              out_last_pixel,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bmp565_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bmp565_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bmp565_pkg::CFG_DATA_W-1:0] prdata,
  output logic                              pready
);

  localparam int FW = bmp565_pkg::FRAME_W;

  logic [FW-1:0] frame_width_r, frame_width_nxt;
  logic [FW-1:0] frame_height_r, frame_height_nxt;
  logic          cfg_wr;
  logic          cfg_idx;

  logic               q_push, q_full, q_pop, q_valid;
  bmp565_pkg::token_t q_push_data, q_pop_data;

  // Register access
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[2];

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_wr) begin
      case (cfg_idx)
        bmp565_pkg::REG_FRAME_WIDTH:  frame_width_nxt  = pwdata[FW-1:0];
        bmp565_pkg::REG_FRAME_HEIGHT: frame_height_nxt = pwdata[FW-1:0];
        default: frame_width_nxt = frame_width_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      bmp565_pkg::REG_FRAME_WIDTH:  prdata = bmp565_pkg::CFG_DATA_W'(frame_width_r);
      bmp565_pkg::REG_FRAME_HEIGHT: prdata = bmp565_pkg::CFG_DATA_W'(frame_height_r);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bmp565_pkg::FRAME_WIDTH_RST;
      frame_height_r <= bmp565_pkg::FRAME_HEIGHT_RST;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
    end
  end

  bmp565_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_file_start (in_file_start),
    .frame_width   (frame_width_r),
    .frame_height  (frame_height_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_push_data)
  );

  bmp565_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .q_valid   (q_valid)
  );

  bmp565_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_data            (q_pop_data),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_pixel_rgb565  (out_pixel_rgb565),
    .out_pixel_address (out_pixel_address),
    .out_last_pixel    (out_last_pixel)
  );

endmodule

[rtl/bmp565_front.sv]
// Byte parser: header capture and check, offset skip, pixel assembly, row padding.
`timescale 1ns / 1ps

module bmp565_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_file_start,
  input  logic [bmp565_pkg::FRAME_W-1:0] frame_width,
  input  logic [bmp565_pkg::FRAME_W-1:0] frame_height,
  input  logic                          q_full,
  output logic                          q_push,
  output bmp565_pkg::token_t            q_data
);

  // Header byte positions
  localparam logic [5:0] POS_SIG_LO = 6'd0;
  localparam logic [5:0] POS_SIG_HI = 6'd1;
  localparam logic [5:0] POS_OFF_LO = 6'd10;
  localparam logic [5:0] POS_OFF_HI = 6'd13;
  localparam logic [5:0] POS_WID_LO = 6'd18;
  localparam logic [5:0] POS_WID_HI = 6'd21;
  localparam logic [5:0] POS_HGT_LO = 6'd22;
  localparam logic [5:0] POS_HGT_HI = 6'd25;
  localparam logic [5:0] POS_DEP_LO = 6'd28;
  localparam logic [5:0] POS_DEP_HI = 6'd29;

  localparam int FW = bmp565_pkg::FRAME_W;
  localparam int CW = bmp565_pkg::COL_W;
  localparam int RW = bmp565_pkg::ROW_W;
  localparam int AW = bmp565_pkg::ADDR_W;

  bmp565_pkg::phase_t phase_r, phase_nxt, ph_cur;
  logic [1:0]    comp_r, comp_nxt;
  logic [31:0]   pos_r, pos_nxt, pos_cur;
  logic [15:0]   sig_r, sig_nxt;
  logic [31:0]   off_r, off_nxt;
  logic [31:0]   hw_r, hw_nxt;
  logic [31:0]   hh_r, hh_nxt;
  logic [15:0]   dep_r, dep_nxt;
  logic [7:0]    blue_r, blue_nxt;
  logic [7:0]    green_r, green_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [AW-1:0] prod_r;

  logic            acc;
  logic            hdr_ok;
  logic            row_end;
  logic            last_pix;
  logic [FW-1:0]   hh_m1;
  logic [2*FW-1:0] prod_full;
  logic [CW:0]     col_p1;
  logic [RW:0]     row_p1;

  // Handshake: stall only while the queue is full
  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  // A file start overrides whatever was in progress
  assign ph_cur  = in_file_start ? bmp565_pkg::PH_HEADER : phase_r;
  assign pos_cur = in_file_start ? '0 : pos_r;

  // Header check against the configured frame size
  always_comb begin
    hdr_ok = (frame_width != '0) && (32'(frame_width) <= 32'(bmp565_pkg::MAX_WIDTH)) &&
             (frame_height != '0) && (32'(frame_height) <= 32'(bmp565_pkg::MAX_HEIGHT)) &&
             (sig_r == bmp565_pkg::BMP_SIGNATURE) &&
             (hw_r == 32'(frame_width)) && (hh_r == 32'(frame_height)) &&
             (dep_r == bmp565_pkg::BMP_DEPTH);
  end

  // Start address of the bottom file row, (H-1)*W, settled long before the last header byte
  assign hh_m1     = hh_r[FW-1:0] - FW'(1);
  assign prod_full = hh_m1 * hw_r[FW-1:0];

  // Row and image end detection
  assign col_p1   = {1'b0, col_r} + (CW+1)'(1);
  assign row_p1   = {1'b0, row_r} + (RW+1)'(1);
  assign row_end  = 32'(col_p1) >= hw_r;
  assign last_pix = row_end && (32'(row_p1) >= hh_r);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      unique case (ph_cur)
        bmp565_pkg::PH_HEADER: begin
          phase_nxt = bmp565_pkg::PH_HEADER;
          if (pos_cur == bmp565_pkg::LAST_HDR_POS) begin
            if (!hdr_ok) begin
              phase_nxt = bmp565_pkg::PH_DONE;
            end else if (off_r <= bmp565_pkg::HEADER_BYTES) begin
              phase_nxt = bmp565_pkg::PH_PIXELS;
            end else begin
              phase_nxt = bmp565_pkg::PH_SKIP;
            end
          end
        end
        bmp565_pkg::PH_SKIP: begin
          if (pos_r + 32'd1 == off_r) begin
            phase_nxt = bmp565_pkg::PH_PIXELS;
          end
        end
        bmp565_pkg::PH_PAD: begin
          if (comp_r <= 2'd1) begin
            phase_nxt = bmp565_pkg::PH_PIXELS;
          end
        end
        bmp565_pkg::PH_PIXELS: begin
          if (comp_r == 2'd2) begin
            if (last_pix) begin
              phase_nxt = bmp565_pkg::PH_DONE;
            end else if (row_end && (hw_r[1:0] != 2'd0)) begin
              phase_nxt = bmp565_pkg::PH_PAD;
            end
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // Datapath updates and queue push
  always_comb begin
    logic [5:0] pos6;
    logic [1:0] lane;
    pos6      = pos_cur[5:0];
    lane      = 2'd0;
    comp_nxt  = comp_r;
    pos_nxt   = pos_r;
    sig_nxt   = sig_r;
    off_nxt   = off_r;
    hw_nxt    = hw_r;
    hh_nxt    = hh_r;
    dep_nxt   = dep_r;
    blue_nxt  = blue_r;
    green_nxt = green_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    base_nxt  = base_r;
    q_push    = 1'b0;
    q_data    = '0;
    if (acc) begin
      case (ph_cur)
        bmp565_pkg::PH_HEADER: begin
          // capture the header fields, little-endian
          case (pos6) inside
            [POS_SIG_LO:POS_SIG_HI]: begin
              sig_nxt[{pos6[0], 3'b000} +: 8] = in_data_byte;
            end
            [POS_OFF_LO:POS_OFF_HI]: begin
              lane = 2'(pos6 - POS_OFF_LO);
              off_nxt[{lane, 3'b000} +: 8] = in_data_byte;
            end
            [POS_WID_LO:POS_WID_HI]: begin
              lane = 2'(pos6 - POS_WID_LO);
              hw_nxt[{lane, 3'b000} +: 8] = in_data_byte;
            end
            [POS_HGT_LO:POS_HGT_HI]: begin
              lane = 2'(pos6 - POS_HGT_LO);
              hh_nxt[{lane, 3'b000} +: 8] = in_data_byte;
            end
            [POS_DEP_LO:POS_DEP_HI]: begin
              dep_nxt[{pos6[0], 3'b000} +: 8] = in_data_byte;
            end
            default: begin
              lane = 2'd0;
            end
          endcase
          if (pos_cur == bmp565_pkg::LAST_HDR_POS) begin
            pos_nxt = bmp565_pkg::HEADER_BYTES;
            if (!hdr_ok) begin
              q_push      = 1'b1;
              q_data.kind = bmp565_pkg::KIND_REJECT;
            end else begin
              comp_nxt = 2'd0;
              col_nxt  = '0;
              row_nxt  = '0;
              base_nxt = prod_r;
            end
          end else begin
            pos_nxt = pos_cur + 32'd1;
          end
        end
        bmp565_pkg::PH_SKIP: begin
          pos_nxt = pos_r + 32'd1;
        end
        bmp565_pkg::PH_PAD: begin
          comp_nxt = (comp_r <= 2'd1) ? 2'd0 : comp_r - 2'd1;
        end
        bmp565_pkg::PH_PIXELS: begin
          if (comp_r == 2'd0) begin
            blue_nxt = in_data_byte;
            comp_nxt = 2'd1;
          end else if (comp_r == 2'd1) begin
            green_nxt = in_data_byte;
            comp_nxt  = 2'd2;
          end else begin
            // red byte completes the pixel
            q_push          = 1'b1;
            q_data.kind     = bmp565_pkg::KIND_PIXEL;
            q_data.last     = last_pix;
            q_data.red      = in_data_byte;
            q_data.green    = green_r;
            q_data.blue     = blue_r;
            q_data.row_base = base_r;
            q_data.col      = col_r;
            comp_nxt        = 2'd0;
            if (!last_pix) begin
              if (row_end) begin
                col_nxt  = '0;
                row_nxt  = row_r + RW'(1);
                base_nxt = base_r - hw_r[AW-1:0];
                if (hw_r[1:0] != 2'd0) begin
                  comp_nxt = hw_r[1:0];
                end
              end else begin
                col_nxt = col_r + CW'(1);
              end
            end
          end
        end
        default: begin
          comp_nxt = comp_r;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bmp565_pkg::PH_IDLE;
      comp_r  <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      comp_r  <= comp_nxt;
    end
  end

  // Header fields, counters and held bytes
  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    sig_r   <= sig_nxt;
    off_r   <= off_nxt;
    hw_r    <= hw_nxt;
    hh_r    <= hh_nxt;
    dep_r   <= dep_nxt;
    blue_r  <= blue_nxt;
    green_r <= green_nxt;
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    base_r  <= base_nxt;
    prod_r  <= prod_full[AW-1:0];
  end

`ifndef ASSERT_OFF
  // The last pixel ends the file
  a_last_ends_file: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_data.last |=> phase_r == bmp565_pkg::PH_DONE)
    else $error("last pixel did not end the file");

  // A rejected header ends the file
  a_reject_ends_file: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && (q_data.kind == bmp565_pkg::KIND_REJECT) |=> phase_r == bmp565_pkg::PH_DONE)
    else $error("reject did not end the file");

  // Padding always has at least one byte left to skip
  a_pad_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == bmp565_pkg::PH_PAD |-> comp_r != 2'd0)
    else $error("padding phase with zero count");

  // Pixel assembly never goes past the red byte
  a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == bmp565_pkg::PH_PIXELS |-> comp_r != 2'd3)
    else $error("component index out of range");
`endif

endmodule

[rtl/bmp565_queue.sv]
// Two-entry queue of pending results between the parser and the output stage.
`timescale 1ns / 1ps

module bmp565_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bmp565_pkg::token_t push_data,
  output logic               full,
  input  logic               pop,
  output bmp565_pkg::token_t pop_data,
  output logic               q_valid
);

  localparam int PW = bmp565_pkg::QPTR_W;
  localparam int NW = bmp565_pkg::QCNT_W;
  localparam int QD = bmp565_pkg::QDEPTH;

  bmp565_pkg::token_t ent_r [QD];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;

  assign full     = cnt_r == NW'(QD);
  assign q_valid  = cnt_r != '0;
  assign pop_data = ent_r[rptr_r];

  // Pointer and fill count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(QD - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(QD - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NW'(QD))
    else $error("queue count above depth");
`endif

endmodule

[rtl/bmp565_back.sv]
// Output stage: RGB565 packing, frame address, and the registered result channel.
`timescale 1ns / 1ps

module bmp565_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  bmp565_pkg::token_t            q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_result_kind,
  output logic [bmp565_pkg::RGB_W-1:0]  out_pixel_rgb565,
  output logic [bmp565_pkg::ADDR_W-1:0] out_pixel_address,
  output logic                          out_last_pixel
);

  localparam int AW = bmp565_pkg::ADDR_W;

  logic          valid_r, valid_nxt;
  logic          kind_r;
  logic [15:0]   rgb_r, rgb_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic          last_r, last_nxt;

  // Take the next entry whenever the output register is empty or draining
  assign q_pop = q_valid && (!valid_r || !out_stall);

  // Pack the pixel and form its frame address; a reject carries zeros
  always_comb begin
    rgb_nxt  = '0;
    addr_nxt = '0;
    last_nxt = 1'b0;
    if (q_data.kind == bmp565_pkg::KIND_PIXEL) begin
      rgb_nxt  = {q_data.red[7:3], q_data.green[7:2], q_data.blue[7:3]};
      addr_nxt = q_data.row_base + AW'(q_data.col);
      last_nxt = q_data.last;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r <= q_data.kind;
      rgb_r  <= rgb_nxt;
      addr_r <= addr_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_result_kind   = kind_r;
  assign out_pixel_rgb565  = rgb_r;
  assign out_pixel_address = addr_r;
  assign out_last_pixel    = last_r;

endmodule

[dv/tb.sv]
// Self-checking testbench for the BMP 24-bit to RGB565 stream decoder.
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_ITEMS  = 300;
  localparam int LONG_HOLD     = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 2000;

  // One byte of the file stream and one decoded transaction
  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } file_byte_t;

  typedef struct packed {
    logic                          kind;
    logic [bmp565_pkg::RGB_W-1:0]  rgb;
    logic [bmp565_pkg::ADDR_W-1:0] addr;
    logic                          last;
  } px_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [7:0]                        in_data_byte = '0;
  logic                              in_file_start = 1'b0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic                              out_result_kind;
  logic [bmp565_pkg::RGB_W-1:0]      out_pixel_rgb565;
  logic [bmp565_pkg::ADDR_W-1:0]     out_pixel_address;
  logic                              out_last_pixel;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [bmp565_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [bmp565_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [bmp565_pkg::CFG_DATA_W-1:0] prdata;
  logic                              pready;

  bmp24_to_rgb565_stream_decoder i_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data_byte, .in_file_start,
    .out_valid, .out_stall, .out_result_kind, .out_pixel_rgb565,
    .out_pixel_address, .out_last_pixel,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus queue and expected decoder output
  file_byte_t pending_bytes[$];
  px_result_t expected_decodes[$];

  // Decoder shadow: frame size registers and parse state
  logic [bmp565_pkg::FRAME_W-1:0] cur_width = bmp565_pkg::FRAME_WIDTH_RST;
  logic [bmp565_pkg::FRAME_W-1:0] cur_height = bmp565_pkg::FRAME_HEIGHT_RST;
  bmp565_pkg::phase_t             dec_phase;
  logic [31:0]                    dec_pos, dec_offset, dec_hdr_w, dec_hdr_h;
  logic [15:0]                    dec_sig, dec_depth, dec_held;
  logic [1:0]                     dec_lane;
  logic [31:0]                    dec_col, dec_row;
  logic [bmp565_pkg::ADDR_W-1:0]  dec_row_base;

  // Knobs and statistics
  bit send_idling = 1'b0;
  bit recv_idling = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int file_bytes = 0;
  int files_queued = 0;
  int bytes_accepted = 0;
  int pixels_seen = 0;
  int rejects_seen = 0;
  int reg_writes = 0;
  file_byte_t next_byte;
  px_result_t got, want;

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic clear_decoder();
    dec_phase    = bmp565_pkg::PH_IDLE;
    dec_pos      = '0;
    dec_offset   = '0;
    dec_hdr_w    = '0;
    dec_hdr_h    = '0;
    dec_sig      = '0;
    dec_depth    = '0;
    dec_held     = '0;
    dec_lane     = '0;
    dec_col      = '0;
    dec_row      = '0;
    dec_row_base = '0;
  endtask

  function automatic bit header_passes();
    if (cur_width == 0 || cur_width > bmp565_pkg::MAX_WIDTH) return 1'b0;
    if (cur_height == 0 || cur_height > bmp565_pkg::MAX_HEIGHT) return 1'b0;
    return dec_sig == bmp565_pkg::BMP_SIGNATURE && dec_hdr_w == cur_width &&
           dec_hdr_h == cur_height && dec_depth == bmp565_pkg::BMP_DEPTH;
  endfunction

  // Advance the shadow decoder by one accepted byte, queue any result
  task automatic decode_byte(input logic [7:0] d, input logic fs);
    px_result_t r;
    logic       row_end, last;
    logic [31:0] base;
    r = '0;
    if (fs) begin
      clear_decoder();
      dec_phase = bmp565_pkg::PH_HEADER;
    end
    case (dec_phase)
      bmp565_pkg::PH_HEADER: begin
        case (dec_pos)
          0: dec_sig[7:0] = d;
          1: dec_sig[15:8] = d;
          10, 11, 12, 13: dec_offset[(dec_pos - 10) * 8 +: 8] = d;
          18, 19, 20, 21: dec_hdr_w[(dec_pos - 18) * 8 +: 8] = d;
          22, 23, 24, 25: dec_hdr_h[(dec_pos - 22) * 8 +: 8] = d;
          28: dec_depth[7:0] = d;
          29: dec_depth[15:8] = d;
          default: ;
        endcase
        if (dec_pos == bmp565_pkg::LAST_HDR_POS) begin
          dec_pos = bmp565_pkg::HEADER_BYTES;
          if (!header_passes()) begin
            dec_phase = bmp565_pkg::PH_DONE;
            r.kind = bmp565_pkg::KIND_REJECT;
            expected_decodes.push_back(r);
          end else begin
            if (dec_offset <= bmp565_pkg::HEADER_BYTES) dec_phase = bmp565_pkg::PH_PIXELS;
            else dec_phase = bmp565_pkg::PH_SKIP;
            dec_lane = '0;
            dec_col = '0;
            dec_row = '0;
            base = (dec_hdr_h - 1) * dec_hdr_w;
            dec_row_base = base[bmp565_pkg::ADDR_W-1:0];
          end
        end else begin
          dec_pos++;
        end
      end
      bmp565_pkg::PH_SKIP: begin
        dec_pos++;
        if (dec_pos == dec_offset) dec_phase = bmp565_pkg::PH_PIXELS;
      end
      bmp565_pkg::PH_PAD: begin
        dec_pos++;
        if (dec_lane <= 1) begin
          dec_lane = '0;
          dec_phase = bmp565_pkg::PH_PIXELS;
        end else begin
          dec_lane--;
        end
      end
      bmp565_pkg::PH_PIXELS: begin
        dec_pos++;
        if (dec_lane == 0) begin
          dec_held = {d, 8'h00};
          dec_lane = 2'd1;
        end else if (dec_lane == 1) begin
          dec_held[7:0] = d;
          dec_lane = 2'd2;
        end else begin
          // red from this byte, green and blue from the held pair
          row_end = (dec_col + 1 >= dec_hdr_w);
          last = row_end && (dec_row + 1 >= dec_hdr_h);
          r.kind = bmp565_pkg::KIND_PIXEL;
          r.rgb = {d[7:3], dec_held[7:2], dec_held[15:11]};
          r.addr = dec_row_base + dec_col[bmp565_pkg::ADDR_W-1:0];
          r.last = last;
          expected_decodes.push_back(r);
          dec_lane = '0;
          if (last) begin
            dec_phase = bmp565_pkg::PH_DONE;
          end else if (row_end) begin
            dec_col = '0;
            dec_row++;
            dec_row_base = dec_row_base - dec_hdr_w[bmp565_pkg::ADDR_W-1:0];
            if (dec_hdr_w[1:0] != 0) begin
              dec_lane = dec_hdr_w[1:0];
              dec_phase = bmp565_pkg::PH_PAD;
            end
          end else begin
            dec_col++;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Byte driver: offers queued bytes, predicts each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data_byte <= '0;
      in_file_start <= 1'b0;
      send_gap = 0;
      clear_decoder();
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        decode_byte(in_data_byte, in_file_start);
        bytes_accepted++;
      end
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (pending_bytes.size() == 0) begin
        in_valid <= 1'b0;
      end else if (send_idling && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        send_gap = $urandom_range(0, 5);
      end else begin
        next_byte = pending_bytes.pop_front();
        in_valid <= 1'b1;
        in_data_byte <= next_byte.data;
        in_file_start <= next_byte.start;
      end
    end
  end

  // Result monitor: checks each transaction and drives the stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_result_kind, out_pixel_rgb565, out_pixel_address, out_last_pixel};
        if (got.kind == bmp565_pkg::KIND_REJECT) rejects_seen++;
        else pixels_seen++;
        if (expected_decodes.size() == 0) begin
          note_mismatch($sformatf("result with none expected: kind %0d rgb %h addr %0d last %0d",
                                  got.kind, got.rgb, got.addr, got.last));
        end else begin
          want = expected_decodes.pop_front();
          if (got.kind !== want.kind || got.rgb !== want.rgb ||
              got.addr !== want.addr || got.last !== want.last)
            note_mismatch($sformatf(
              "exp kind %0d rgb %h addr %0d last %0d, got kind %0d rgb %h addr %0d last %0d",
              want.kind, want.rgb, want.addr, want.last,
              got.kind, got.rgb, got.addr, got.last));
        end
      end
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (recv_idling && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 5);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic void push_byte(input logic [7:0] d, input logic fs);
    file_byte_t b;
    b.data = d;
    b.start = fs;
    pending_bytes.push_back(b);
  endfunction

  // Random filler bytes; optionally some of them restart a file
  function automatic void push_random(input int n, input bit allow_start);
    repeat (n) push_byte(8'($urandom), allow_start && $urandom_range(0, 9) == 0);
  endfunction

  function automatic int image_bytes(input int w, input int h);
    return h * 3 * w + (h - 1) * (w % 4);
  endfunction

  // Header with the given fields (other bytes random), skip gap, then body
  task automatic queue_file(input logic [15:0] sig, input logic [31:0] fw, input logic [31:0] fh,
                            input logic [15:0] dep, input logic [31:0] off,
                            input int gap, input int body);
    logic [7:0] hdr [0:53];
    for (int i = 0; i < 54; i++) hdr[i] = 8'($urandom);
    hdr[0] = sig[7:0];
    hdr[1] = sig[15:8];
    for (int k = 0; k < 4; k++) begin
      hdr[10 + k] = off[8 * k +: 8];
      hdr[18 + k] = fw[8 * k +: 8];
      hdr[22 + k] = fh[8 * k +: 8];
    end
    hdr[28] = dep[7:0];
    hdr[29] = dep[15:8];
    for (int i = 0; i < 54; i++) push_byte(hdr[i], i == 0);
    push_random(gap + body, 1'b0);
    file_bytes += 54 + gap + body;
    files_queued++;
  endtask

  // One file of a random kind for the current frame size
  task automatic queue_random_file(input int w, input int h, input bit usable);
    logic [15:0] sig, dep;
    logic [31:0] fw, fh, off;
    int gap, body, full, pick;
    sig = bmp565_pkg::BMP_SIGNATURE;
    dep = bmp565_pkg::BMP_DEPTH;
    fw = w;
    fh = h;
    off = bmp565_pkg::HEADER_BYTES;
    gap = 0;
    full = image_bytes(w, h);
    pick = $urandom_range(0, 99);
    if (pick >= 90) begin
      // stray bytes, now and then with a file start among them
      push_random($urandom_range(1, 6), 1'b1);
      return;
    end
    // pixel-data offset: mostly exact, some short ones, some with a gap
    case ($urandom_range(0, 9))
      0, 1: off = $urandom_range(0, 53);
      2, 3, 4: begin
        gap = $urandom_range(1, 12);
        off = bmp565_pkg::HEADER_BYTES + gap;
      end
      default: ;
    endcase
    if (!usable) begin
      body = $urandom_range(0, 6);
    end else if (pick < 65) begin
      body = full;
    end else if (pick < 78) begin
      case ($urandom_range(0, 3))
        0: sig = sig ^ 16'($urandom_range(1, 65535));
        1: fw = fw ^ (32'd1 << $urandom_range(0, 31));
        2: fh = fh ^ (32'd1 << $urandom_range(0, 31));
        default: dep = dep ^ 16'($urandom_range(1, 65535));
      endcase
      body = $urandom_range(0, 8);
    end else begin
      // cut short; the next file start drops it
      body = $urandom_range(0, full - 1);
    end
    queue_file(sig, fw, fh, dep, off, gap, body);
    if (usable && pick < 65 && $urandom_range(0, 3) == 0)
      push_random($urandom_range(1, 3), 1'b0);
  endtask

  // Write a frame size register, then read it back
  task automatic cfg_write(input logic idx, input logic [bmp565_pkg::FRAME_W-1:0] val);
    logic [bmp565_pkg::CFG_DATA_W-1:0] word;
    word = '0;
    word[bmp565_pkg::FRAME_W-1:0] = val;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == bmp565_pkg::REG_FRAME_WIDTH) cur_width = val;
    else cur_height = val;
    reg_writes++;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (prdata !== word)
      note_mismatch($sformatf("register %0d read %h, expected %h", idx, prdata, word));
  endtask

  // Wait until every byte is taken and every result has come, then settle
  task automatic settle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_decodes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int w, h, tmp, start_bytes;
    bit usable;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    send_idling = 1'b1;
    recv_idling = 1'b1;

    // Stray bytes before any file, then reset frame size with a cut-short image,
    // a restart inside the header, and a bad signature with bytes after it
    push_random(3, 1'b0);
    queue_file(bmp565_pkg::BMP_SIGNATURE, 320, 240, bmp565_pkg::BMP_DEPTH,
               bmp565_pkg::HEADER_BYTES, 0, 12);
    push_byte(8'($urandom), 1'b1);
    push_random(20, 1'b0);
    queue_file(bmp565_pkg::BMP_SIGNATURE ^ 16'h0100, 320, 240, bmp565_pkg::BMP_DEPTH,
               bmp565_pkg::HEADER_BYTES, 0, 5);
    settle();

    // Smallest frame, short offset, extreme pixel bytes, bytes after the image
    cfg_write(bmp565_pkg::REG_FRAME_WIDTH, 11'd1);
    cfg_write(bmp565_pkg::REG_FRAME_HEIGHT, 11'd1);
    queue_file(bmp565_pkg::BMP_SIGNATURE, 1, 1, bmp565_pkg::BMP_DEPTH, 32'd20, 0, 0);
    repeat (3) push_byte(8'hFF, 1'b0);
    push_random(4, 1'b0);
    settle();

    // Offset gap, row padding, and a wrong depth, width and height in turn
    cfg_write(bmp565_pkg::REG_FRAME_WIDTH, 11'd3);
    cfg_write(bmp565_pkg::REG_FRAME_HEIGHT, 11'd2);
    queue_file(bmp565_pkg::BMP_SIGNATURE, 3, 2, bmp565_pkg::BMP_DEPTH, 32'd60, 6, 0);
    repeat (3) push_byte(8'h00, 1'b0);
    push_random(image_bytes(3, 2) - 3, 1'b0);
    queue_file(bmp565_pkg::BMP_SIGNATURE, 3, 2, 16'd32, bmp565_pkg::HEADER_BYTES, 0, 3);
    queue_file(bmp565_pkg::BMP_SIGNATURE, 4, 2, bmp565_pkg::BMP_DEPTH,
               bmp565_pkg::HEADER_BYTES, 0, 3);
    queue_file(bmp565_pkg::BMP_SIGNATURE, 3, 1, bmp565_pkg::BMP_DEPTH,
               bmp565_pkg::HEADER_BYTES, 0, 3);
    settle();

    // Long receiver hold while bytes keep coming
    cfg_write(bmp565_pkg::REG_FRAME_WIDTH, 11'd8);
    cfg_write(bmp565_pkg::REG_FRAME_HEIGHT, 11'd4);
    send_idling = 1'b0;
    recv_idling = 1'b0;
    queue_file(bmp565_pkg::BMP_SIGNATURE, 8, 4, bmp565_pkg::BMP_DEPTH,
               bmp565_pkg::HEADER_BYTES, 0, image_bytes(8, 4));
    hold_requests++;
    settle();

    // Frame size changed in the middle of an image
    send_idling = 1'b1;
    recv_idling = 1'b1;
    cfg_write(bmp565_pkg::REG_FRAME_WIDTH, 11'd2);
    cfg_write(bmp565_pkg::REG_FRAME_HEIGHT, 11'd3);
    queue_file(bmp565_pkg::BMP_SIGNATURE, 2, 3, bmp565_pkg::BMP_DEPTH,
               bmp565_pkg::HEADER_BYTES, 0, 8);
    settle();
    cfg_write(bmp565_pkg::REG_FRAME_WIDTH, 11'd5);
    cfg_write(bmp565_pkg::REG_FRAME_HEIGHT, 11'd5);
    push_random(image_bytes(2, 3) - 8, 1'b0);
    settle();

    // Unusable frame sizes reject even a matching header
    cfg_write(bmp565_pkg::REG_FRAME_WIDTH, 11'd0);
    queue_file(bmp565_pkg::BMP_SIGNATURE, 0, 5, bmp565_pkg::BMP_DEPTH,
               bmp565_pkg::HEADER_BYTES, 0, 2);
    settle();
    cfg_write(bmp565_pkg::REG_FRAME_WIDTH, 11'd2047);
    cfg_write(bmp565_pkg::REG_FRAME_HEIGHT, 11'd1);
    queue_file(bmp565_pkg::BMP_SIGNATURE, 2047, 1, bmp565_pkg::BMP_DEPTH,
               bmp565_pkg::HEADER_BYTES, 0, 2);
    settle();
    cfg_write(bmp565_pkg::REG_FRAME_WIDTH, 11'd1024);
    cfg_write(bmp565_pkg::REG_FRAME_HEIGHT, 11'd0);
    queue_file(bmp565_pkg::BMP_SIGNATURE, 1024, 0, bmp565_pkg::BMP_DEPTH,
               bmp565_pkg::HEADER_BYTES, 0, 2);
    settle();

    // Largest frame: top addresses, a huge offset cut by a restart in the skip
    cfg_write(bmp565_pkg::REG_FRAME_HEIGHT, 11'd1024);
    queue_file(bmp565_pkg::BMP_SIGNATURE, 1024, 1024, bmp565_pkg::BMP_DEPTH,
               bmp565_pkg::HEADER_BYTES, 0, 30);
    queue_file(bmp565_pkg::BMP_SIGNATURE, 1024, 1024, bmp565_pkg::BMP_DEPTH,
               32'hFFFF_FFF0, 20, 0);
    queue_file(bmp565_pkg::BMP_SIGNATURE, 1024, 1024, bmp565_pkg::BMP_DEPTH,
               bmp565_pkg::HEADER_BYTES, 0, 6);

    // Random frame sizes, each with a few files of mixed kinds
    start_bytes = file_bytes;
    while (file_bytes - start_bytes < RANDOM_ITEMS) begin
      settle();
      usable = 1'b1;
      case ($urandom_range(0, 7))
        0: begin
          usable = 1'b0;
          case ($urandom_range(0, 2))
            0: w = 0;
            1: w = bmp565_pkg::MAX_WIDTH + 1;
            default: w = 2047;
          endcase
          h = $urandom_range(1, 4);
          if ($urandom_range(0, 1) == 1) begin
            tmp = w;
            w = h;
            h = tmp;
          end
        end
        1: begin
          w = $urandom_range(9, 40);
          h = $urandom_range(1, 2);
        end
        default: begin
          w = $urandom_range(1, 8);
          h = $urandom_range(1, 4);
        end
      endcase
      cfg_write(bmp565_pkg::REG_FRAME_WIDTH, bmp565_pkg::FRAME_W'(w));
      cfg_write(bmp565_pkg::REG_FRAME_HEIGHT, bmp565_pkg::FRAME_W'(h));
      send_idling = $urandom_range(0, 2) != 0;
      recv_idling = $urandom_range(0, 2) != 0;
      repeat ($urandom_range(1, 3)) queue_random_file(w, h, usable);
    end

    // Closing stretch with no idling on either side
    settle();
    send_idling = 1'b0;
    recv_idling = 1'b0;
    cfg_write(bmp565_pkg::REG_FRAME_WIDTH, 11'd7);
    cfg_write(bmp565_pkg::REG_FRAME_HEIGHT, 11'd3);
    repeat (2) queue_random_file(7, 3, 1'b1);
    settle();

    $display("Run covered %0d bytes accepted across %0d files and %0d register writes",
             bytes_accepted, files_queued, reg_writes);
    $display("Checked %0d pixel and %0d header reject transactions",
             pixels_seen, rejects_seen);
    if (mismatches == 0 && expected_decodes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
rtl/bmp565_pkg.sv
rtl/bmp565_front.sv
rtl/bmp565_queue.sv
rtl/bmp565_back.sv
rtl/bmp24_to_rgb565_stream_decoder.sv
dv/tb.sv
